@@ rtl/rain_period_accumulator_top_defines.svh @@
// Assertion macros used by the rain period accumulator checker.
`ifndef RAIN_PERIOD_ACCUMULATOR_TOP_DEFINES_SVH
`define RAIN_PERIOD_ACCUMULATOR_TOP_DEFINES_SVH

// Condition and consequence in the same cycle.
`define RPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define RPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rpa_pkg.sv @@
// Shared constants and types of the rain period accumulator.
package rpa_pkg;

   localparam int MINUTE_SLOTS = 60;
   localparam int HOUR_SLOTS   = 24;

   localparam int RAIN_W  = 12;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int MDAY_W  = 5;
   localparam int MONTH_W = 4;
   localparam int TOTAL_W = 20;

   // Running sum widths: 60 * 4095 fits in 18 bits, 24 * (2^20 - 1) in 25 bits.
   localparam int MSUM_W = 18;
   localparam int HSUM_W = 25;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // One reading with its local time stamp.
   typedef struct packed {
      logic [RAIN_W-1:0]  rain;
      logic [MIN_W-1:0]   minute;
      logic [HOUR_W-1:0]  hour;
      logic [MDAY_W-1:0]  mday;
      logic [MONTH_W-1:0] month;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic [TOTAL_W-1:0] total_hour;
      logic [TOTAL_W-1:0] total_day;
      logic [TOTAL_W-1:0] total_month;
      logic [TOTAL_W-1:0] total_year;
      logic [TOTAL_W-1:0] rolling_sixty_min;
      logic [TOTAL_W-1:0] rolling_day;
   } result_type;

   // Which ring slots the item in the update stage writes.
   typedef struct packed {
      logic minute_wr;
      logic hour_wr;
   } ring_upd_type;

endpackage

@@ rtl/rpa_ring_ram.sv @@
// Ring slot memory with a registered read port and per-entry valid bits.
module rpa_ring_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 60,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] q_ff;
   logic             hit_ff;

   // Storage and registered read port; a read in the write cycle sees old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   // Valid bits stand in for clearing the array: unwritten slots read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? q_ff : '0;

endmodule

@@ rtl/rpa_totals.sv @@
// Calendar totals and ring running sums, updated once per reading.
module rpa_totals
   import rpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  item_type            item,
   input  ring_upd_type        upd,
   input  logic [RAIN_W-1:0]   minute_old,
   input  logic [TOTAL_W-1:0]  hour_old,
   output logic [TOTAL_W-1:0]  hour_acc_new,
   output result_type          result
);

   logic [TOTAL_W-1:0] hour_acc_ff, day_acc_ff, month_acc_ff, year_acc_ff;
   logic [TOTAL_W-1:0] hour_acc_in, day_acc_in, month_acc_in, year_acc_in;
   logic [MSUM_W-1:0]  msum_ff, msum_in;
   logic [HSUM_W-1:0]  hsum_ff, hsum_in;
   logic               hour_edge, day_edge, month_edge, year_edge;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                  input logic [RAIN_W-1:0]  add);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, acc} + {{(TOTAL_W+1-RAIN_W){1'b0}}, add};
      return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
   endfunction

   // Period boundaries nest: each one also needs the shorter one.
   assign hour_edge  = (item.minute == '0);
   assign day_edge   = hour_edge && (item.hour == '0);
   assign month_edge = day_edge && (item.mday == MDAY_W'(1));
   assign year_edge  = month_edge && (item.month == '0);

   // A boundary restarts the total with this reading.
   always_comb begin
      hour_acc_in  = hour_edge  ? TOTAL_W'(item.rain) : sat_add(hour_acc_ff, item.rain);
      day_acc_in   = day_edge   ? TOTAL_W'(item.rain) : sat_add(day_acc_ff, item.rain);
      month_acc_in = month_edge ? TOTAL_W'(item.rain) : sat_add(month_acc_ff, item.rain);
      year_acc_in  = year_edge  ? TOTAL_W'(item.rain) : sat_add(year_acc_ff, item.rain);
   end

   // Running sums drop the replaced slot and add its new contents.
   always_comb begin
      msum_in = msum_ff;
      hsum_in = hsum_ff;
      if (upd.minute_wr) begin
         msum_in = msum_ff - MSUM_W'(minute_old) + MSUM_W'(item.rain);
      end
      if (upd.hour_wr) begin
         hsum_in = hsum_ff - HSUM_W'(hour_old) + HSUM_W'(hour_acc_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_acc_ff  <= '0;
         day_acc_ff   <= '0;
         month_acc_ff <= '0;
         year_acc_ff  <= '0;
         msum_ff      <= '0;
         hsum_ff      <= '0;
      end else if (advance) begin
         hour_acc_ff  <= hour_acc_in;
         day_acc_ff   <= day_acc_in;
         month_acc_ff <= month_acc_in;
         year_acc_ff  <= year_acc_in;
         msum_ff      <= msum_in;
         hsum_ff      <= hsum_in;
      end
   end

   // Result of this reading; only the 24-hour sum can exceed the output range.
   assign hour_acc_new              = hour_acc_in;
   assign result.total_hour         = hour_acc_in;
   assign result.total_day          = day_acc_in;
   assign result.total_month        = month_acc_in;
   assign result.total_year         = year_acc_in;
   assign result.rolling_sixty_min  = TOTAL_W'(msum_in);
   assign result.rolling_day        = (hsum_in > HSUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                     : hsum_in[TOTAL_W-1:0];

endmodule

@@ rtl/rain_period_accumulator_top.sv @@
// Rain period accumulator: ring memories, update stage and result register.
// Each accepted reading is held in the update stage register, then its result beat in
// the result register on rsp_valid. Throughput: one reading per cycle unless rsp_stall
// holds the result register; the ring read is issued at acceptance and the write-back
// happens in the update stage, with forwarding when two readings meet.
// Reset clears all totals and sums and marks every ring slot as zero.
module rain_period_accumulator_top
   import rpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [RAIN_W-1:0]   req_rain_amount,
   input  logic [MIN_W-1:0]    req_minute_now,
   input  logic [HOUR_W-1:0]   req_hour_now,
   input  logic [MDAY_W-1:0]   req_day_of_month,
   input  logic [MONTH_W-1:0]  req_month_now,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TOTAL_W-1:0]  rsp_total_hour,
   output logic [TOTAL_W-1:0]  rsp_total_day,
   output logic [TOTAL_W-1:0]  rsp_total_month,
   output logic [TOTAL_W-1:0]  rsp_total_year,
   output logic [TOTAL_W-1:0]  rsp_rolling_sixty_min,
   output logic [TOTAL_W-1:0]  rsp_rolling_day
);

   logic               s1_valid_ff;
   item_type           s1_item_ff;
   logic               out_valid_ff;
   result_type         out_ff;
   logic               s1_go, accept;
   logic               req_min_ok, req_hour_ok;
   ring_upd_type       upd;
   logic [RAIN_W-1:0]  min_rd_data, min_old;
   logic [TOTAL_W-1:0] hr_rd_data, hr_old, hour_acc_new;
   logic               min_fwd_ff, hr_fwd_ff;
   logic [RAIN_W-1:0]  min_fwd_data_ff;
   logic [TOTAL_W-1:0] hr_fwd_data_ff;
   result_type         result;

   // Handshake: the update stage moves on when the result register is free or drains.
   assign s1_go     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   assign req_min_ok      = (req_minute_now < MIN_W'(MINUTE_SLOTS));
   assign req_hour_ok     = (req_hour_now < HOUR_W'(HOUR_SLOTS));
   assign upd.minute_wr   = s1_go && (s1_item_ff.minute < MIN_W'(MINUTE_SLOTS));
   assign upd.hour_wr     = s1_go && (s1_item_ff.hour < HOUR_W'(HOUR_SLOTS));

   // Per-minute and per-hour rings.
   rpa_ring_ram #(.WIDTH(RAIN_W), .DEPTH(MINUTE_SLOTS)) u_minute_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_min_ok),
      .rd_addr (req_minute_now),
      .wr_en   (upd.minute_wr),
      .wr_addr (s1_item_ff.minute),
      .wr_data (s1_item_ff.rain),
      .rd_data (min_rd_data)
   );

   rpa_ring_ram #(.WIDTH(TOTAL_W), .DEPTH(HOUR_SLOTS)) u_hour_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_hour_ok),
      .rd_addr (req_hour_now),
      .wr_en   (upd.hour_wr),
      .wr_addr (s1_item_ff.hour),
      .wr_data (hour_acc_new),
      .rd_data (hr_rd_data)
   );

   // A read issued in the same cycle as a write to that slot takes the new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_fwd_ff <= 1'b0;
         hr_fwd_ff  <= 1'b0;
      end else if (accept) begin
         min_fwd_ff <= upd.minute_wr && (s1_item_ff.minute == req_minute_now);
         hr_fwd_ff  <= upd.hour_wr && (s1_item_ff.hour == req_hour_now);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         min_fwd_data_ff <= s1_item_ff.rain;
         hr_fwd_data_ff  <= hour_acc_new;
      end
   end

   assign min_old = min_fwd_ff ? min_fwd_data_ff : min_rd_data;
   assign hr_old  = hr_fwd_ff ? hr_fwd_data_ff : hr_rd_data;

   // Update stage.
   rpa_totals u_totals (
      .clock        (clock),
      .reset        (reset),
      .advance      (s1_go),
      .item         (s1_item_ff),
      .upd          (upd),
      .minute_old   (min_old),
      .hour_old     (hr_old),
      .hour_acc_new (hour_acc_new),
      .result       (result)
   );

   // Stage and result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{rain:   req_rain_amount,
                         minute: req_minute_now,
                         hour:   req_hour_now,
                         mday:   req_day_of_month,
                         month:  req_month_now};
      end
      if (s1_go) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_total_hour        = out_ff.total_hour;
   assign rsp_total_day         = out_ff.total_day;
   assign rsp_total_month       = out_ff.total_month;
   assign rsp_total_year        = out_ff.total_year;
   assign rsp_rolling_sixty_min = out_ff.rolling_sixty_min;
   assign rsp_rolling_day       = out_ff.rolling_day;

endmodule

@@ rtl/rpa_checker.sv @@
// Port-level checks of the rain period accumulator, bound to the top level.
`include "rain_period_accumulator_top_defines.svh"

module rpa_checker
   import rpa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [TOTAL_W-1:0]  rsp_total_hour,
   input logic [TOTAL_W-1:0]  rsp_total_day,
   input logic [TOTAL_W-1:0]  rsp_total_month,
   input logic [TOTAL_W-1:0]  rsp_total_year,
   input logic [TOTAL_W-1:0]  rsp_rolling_sixty_min,
   input logic [TOTAL_W-1:0]  rsp_rolling_day
);

   logic [6*TOTAL_W-1:0] rsp_payload;
   logic                 rsp_held;
   logic                 totals_ordered;
   logic                 sixty_in_range;

   // The whole result beat as one word, and the conditions checked on it.
   assign rsp_payload    = {rsp_total_hour, rsp_total_day, rsp_total_month, rsp_total_year,
                            rsp_rolling_sixty_min, rsp_rolling_day};
   assign rsp_held       = rsp_valid && rsp_stall;
   assign totals_ordered = (rsp_total_hour <= rsp_total_day) &&
                           (rsp_total_day <= rsp_total_month) &&
                           (rsp_total_month <= rsp_total_year);
   assign sixty_in_range = (rsp_rolling_sixty_min <=
                            TOTAL_W'(MINUTE_SLOTS * ((1 << RAIN_W) - 1)));

   // A stalled result beat stays and holds its payload.
   `RPA_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_payload), "stalled beat changed")

   // No result beat right after reset.
   `RPA_ASSERT_NOW(a_rsp_after_reset, $past(reset), !rsp_valid, "result beat right after reset")

   // Nested periods: a longer period always holds at least the shorter one's total.
   `RPA_ASSERT_NOW(a_nesting, rsp_valid, totals_ordered, "calendar totals out of order")

   // Sixty slots of at most 4095 bound the rolling hour.
   `RPA_ASSERT_NOW(a_sixty_bound, rsp_valid, sixty_in_range, "rolling sixty minute sum too large")

endmodule

bind rain_period_accumulator_top rpa_checker u_rpa_checker (.*);
